FILE: rtl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and codes for the serial frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

   localparam int ByteWidth   = 8;
   localparam int CsrIdxWidth = 2;

   // configuration register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_START_BYTE  = 2'd0,
      CSR_DEV_ADDRESS = 2'd1,
      CSR_MAX_LENGTH  = 2'd2
   } csr_index_type;

   localparam logic [ByteWidth-1:0] StartByteReset = 8'd2;
   localparam logic [ByteWidth-1:0] DevAddrReset   = 8'd1;
   localparam logic [ByteWidth-1:0] MaxLenReset    = 8'd32;

   // one result word
   typedef struct packed {
      logic                 payload_valid;
      logic [ByteWidth-1:0] payload_byte;
      logic [ByteWidth-1:0] payload_index;
      logic                 frame_done;
      logic                 frame_ok;
      logic [ByteWidth-1:0] message_opcode;
      logic [ByteWidth-1:0] message_length;
   } result_type;

endpackage

FILE: rtl/sfp_parse.sv
// ----------------------------------------------------------------------------
// sfp_parse
// Frame state machine, config registers and per-byte result build.
// ----------------------------------------------------------------------------
module sfp_parse (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [sfp_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [sfp_pkg::ByteWidth-1:0]     csr_data,
   input  logic                              in_take,
   input  logic [sfp_pkg::ByteWidth-1:0]     in_byte,
   output logic                              res_push,
   output sfp_pkg::result_type               res_word
);

   typedef enum logic [2:0] {
      PH_START    = 3'd0,
      PH_ADDRESS  = 3'd1,
      PH_OPCODE   = 3'd2,
      PH_LENGTH   = 3'd3,
      PH_CHECKSUM = 3'd4,
      PH_PAYLOAD  = 3'd5
   } phase_type;

   logic [sfp_pkg::ByteWidth-1:0] start_byte_ff, dev_addr_ff, max_len_ff;

   phase_type                     phase_ff, phase_in;
   logic [sfp_pkg::ByteWidth-1:0] opcode_ff, opcode_in;
   logic [sfp_pkg::ByteWidth-1:0] length_ff, length_in;
   logic [sfp_pkg::ByteWidth-1:0] chksum_ff, chksum_in;
   logic [sfp_pkg::ByteWidth-1:0] index_ff, index_in;
   logic [sfp_pkg::ByteWidth-1:0] sum_ff, sum_in;

   logic [sfp_pkg::ByteWidth-1:0] sum_next;
   logic [sfp_pkg::ByteWidth:0]   index_plus;
   logic                          last_byte;

   assign sum_next   = sum_ff + in_byte;
   assign index_plus = {1'b0, index_ff} + {{sfp_pkg::ByteWidth{1'b0}}, 1'b1};
   assign last_byte  = index_plus >= {1'b0, length_ff};

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= sfp_pkg::StartByteReset;
         dev_addr_ff   <= sfp_pkg::DevAddrReset;
         max_len_ff    <= sfp_pkg::MaxLenReset;
      end else if (csr_write) begin
         unique case (csr_index)
            sfp_pkg::CSR_START_BYTE:  start_byte_ff <= csr_data;
            sfp_pkg::CSR_DEV_ADDRESS: dev_addr_ff   <= csr_data;
            sfp_pkg::CSR_MAX_LENGTH:  max_len_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      length_in = length_ff;
      chksum_in = chksum_ff;
      index_in  = index_ff;
      sum_in    = sum_ff;
      res_push  = 1'b0;
      res_word  = '0;
      res_word.message_opcode = opcode_ff;
      res_word.message_length = length_ff;
      unique case (phase_ff)
         PH_START: begin
            if (in_byte == start_byte_ff) begin
               opcode_in = '0;
               length_in = '0;
               chksum_in = '0;
               index_in  = '0;
               sum_in    = '0;
               phase_in  = PH_ADDRESS;
            end
         end
         PH_ADDRESS: begin
            phase_in = (in_byte == dev_addr_ff) ? PH_OPCODE : PH_START;
         end
         PH_OPCODE: begin
            opcode_in = in_byte;
            phase_in  = PH_LENGTH;
         end
         PH_LENGTH: begin
            if (in_byte > max_len_ff) begin
               phase_in = PH_START;
            end else begin
               length_in = in_byte;
               phase_in  = PH_CHECKSUM;
            end
         end
         PH_CHECKSUM: begin
            chksum_in = in_byte;
            index_in  = '0;
            sum_in    = '0;
            if (length_ff != '0) begin
               phase_in = PH_PAYLOAD;
            end else begin
               // empty frame: reported good at once
               phase_in            = PH_START;
               res_push            = 1'b1;
               res_word.frame_done = 1'b1;
               res_word.frame_ok   = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            sum_in                 = sum_next;
            res_push               = 1'b1;
            res_word.payload_valid = 1'b1;
            res_word.payload_byte  = in_byte;
            res_word.payload_index = index_ff;
            if (last_byte) begin
               phase_in            = PH_START;
               res_word.frame_done = 1'b1;
               res_word.frame_ok   = ((~sum_next) + 8'd1) == chksum_ff;
            end else begin
               index_in = index_plus[sfp_pkg::ByteWidth-1:0];
            end
         end
         default: begin
            phase_in  = PH_START;
            opcode_in = '0;
            length_in = '0;
            chksum_in = '0;
            index_in  = '0;
            sum_in    = '0;
         end
      endcase
      if (!in_take) begin
         res_push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         opcode_ff <= '0;
         length_ff <= '0;
         chksum_ff <= '0;
         index_ff  <= '0;
         sum_ff    <= '0;
      end else if (in_take) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         length_ff <= length_in;
         chksum_ff <= chksum_in;
         index_ff  <= index_in;
         sum_ff    <= sum_in;
      end
   end

   a_push_phase: assert property (@(posedge clock) disable iff (reset)
      res_push |-> (phase_ff == PH_CHECKSUM) || (phase_ff == PH_PAYLOAD))
      else $error("result outside checksum/payload phase");

   a_done_restart: assert property (@(posedge clock) disable iff (reset)
      res_push && res_word.frame_done |=> phase_ff == PH_START)
      else $error("frame end did not return to start hunt");

   a_payload_bounds: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> (length_ff != '0) && (index_ff < length_ff))
      else $error("payload index out of frame");

endmodule

FILE: rtl/sfp_out.sv
// ----------------------------------------------------------------------------
// sfp_out
// Result register with one skid entry, decouples rsp stall from req side.
// ----------------------------------------------------------------------------
module sfp_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_push,
   input  sfp_pkg::result_type res_word,
   output logic                full,
   output logic                out_valid,
   input  logic                out_stall,
   output sfp_pkg::result_type out_word
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   sfp_pkg::result_type main_word_ff, main_word_in;
   sfp_pkg::result_type skid_word_ff, skid_word_in;
   logic                take;

   assign take      = main_valid_ff && !out_stall;
   assign out_valid = main_valid_ff;
   assign out_word  = main_word_ff;
   assign full      = skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_word_in  = main_word_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_word_in  = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_push) begin
         if (!main_valid_ff || take) begin
            main_word_in  = res_word;
            main_valid_in = 1'b1;
         end else begin
            skid_word_in  = res_word;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_word_ff <= main_word_in;
      skid_word_ff <= skid_word_in;
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without main entry");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !res_push)
      else $error("result pushed while buffer full");

   a_drain_skid: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && take |=> main_valid_ff && !skid_valid_ff)
      else $error("skid entry lost on drain");

endmodule

FILE: rtl/serial_frame_parser_top.sv
// ----------------------------------------------------------------------------
// serial_frame_parser_top
// Byte-serial parser for start-byte framed packets with checksum check.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one received serial byte per word (req_rx_byte). A word is
//   taken when req_valid is high and req_stall is low.
//   rsp channel: zero or one result word per byte. Payload bytes come out
//   with their index; the last payload byte (or the checksum byte of an
//   empty frame) carries frame_done and frame_ok.
//   csr port: csr_write with csr_index / csr_data sets start byte, device
//   address and max payload length. Write only while idle.
// Output: each result is registered before it is driven on rsp.
// Throughput: one byte every cycle while not stalled; the frame state machine
//   plus an 8-bit add/compare is the only logic between input and result regs.
// Stall: the result register has one skid entry behind it; req_stall rises
//   only once both are full, i.e. after the receiver has stalled with two
//   results pending. Bytes that give no result still need that slot free.
// Reset: synchronous; parser hunts for the start byte, registers return
//   to start 2, address 1, max length 32, result buffer empties.
// ----------------------------------------------------------------------------
module serial_frame_parser_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [sfp_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [sfp_pkg::ByteWidth-1:0]   csr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sfp_pkg::ByteWidth-1:0]   req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_payload_valid,
   output logic [sfp_pkg::ByteWidth-1:0]   rsp_payload_byte,
   output logic [sfp_pkg::ByteWidth-1:0]   rsp_payload_index,
   output logic                            rsp_frame_done,
   output logic                            rsp_frame_ok,
   output logic [sfp_pkg::ByteWidth-1:0]   rsp_message_opcode,
   output logic [sfp_pkg::ByteWidth-1:0]   rsp_message_length
);

   logic                in_take;
   logic                res_push;
   logic                buf_full;
   sfp_pkg::result_type res_word;
   sfp_pkg::result_type out_word;

   // stall is registered: the skid slot is occupied
   assign req_stall = buf_full;
   assign in_take   = req_valid && !buf_full;

   sfp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_take   (in_take),
      .in_byte   (req_rx_byte),
      .res_push  (res_push),
      .res_word  (res_word)
   );

   sfp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_push  (res_push),
      .res_word  (res_word),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word)
   );

   assign rsp_payload_valid  = out_word.payload_valid;
   assign rsp_payload_byte   = out_word.payload_byte;
   assign rsp_payload_index  = out_word.payload_index;
   assign rsp_frame_done     = out_word.frame_done;
   assign rsp_frame_ok       = out_word.frame_ok;
   assign rsp_message_opcode = out_word.message_opcode;
   assign rsp_message_length = out_word.message_length;

   a_ok_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok |-> rsp_frame_done)
      else $error("frame_ok without frame_done");

   a_no_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |-> rsp_frame_done
         && (rsp_payload_byte == '0) && (rsp_payload_index == '0))
      else $error("non-payload result carries stray fields");

   a_stall_after_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_stall) && $past(rsp_valid))
      else $error("req_stall rose without receiver stall");

endmodule
